[src/clns_pkg.sv]
// Shared types, codes and tables for the character LCD nibble sequencer.
package clns_pkg;

  // Request kinds on the func field
  localparam logic [2:0] FUNC_INIT   = 3'd0;
  localparam logic [2:0] FUNC_CMD    = 3'd1;
  localparam logic [2:0] FUNC_DATA   = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_CURSOR = 3'd4;
  localparam logic [2:0] FUNC_GLYPH  = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_CLOCKS_PER_US = 3'd0;
  localparam logic [2:0] REG_STROBE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_COMMAND_WAIT  = 3'd2;
  localparam logic [2:0] REG_CHAR_WAIT     = 3'd3;
  localparam logic [2:0] REG_CLEAR_WAIT    = 3'd4;

  localparam logic [15:0] COMMAND_WAIT_RESET = 16'd100;
  localparam logic [15:0] CHAR_WAIT_RESET    = 16'd40;
  localparam logic [15:0] CLEAR_WAIT_RESET   = 16'd2000;

  // Selector for the wait that follows a strobe
  localparam logic [2:0] AFT_ZERO  = 3'd0;
  localparam logic [2:0] AFT_CMD   = 3'd1;
  localparam logic [2:0] AFT_CHAR  = 3'd2;
  localparam logic [2:0] AFT_CLEAR = 3'd3;
  localparam logic [2:0] AFT_5000  = 3'd4;
  localparam logic [2:0] AFT_150   = 3'd5;
  localparam logic [2:0] AFT_1000  = 3'd6;

  localparam logic [15:0] POWER_UP_WAIT_US = 16'd50000;
  localparam logic [3:0]  INIT_LAST_STEP   = 4'd13;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [1:0] CGRAM_PREFIX = 2'b01;

  // One queued job: either the whole init script or one byte
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data;
    logic [2:0] after_sel;
  } clns_job_t;

  typedef struct packed {
    logic [15:0] command_wait;
    logic [15:0] char_wait;
    logic [15:0] clear_wait;
  } clns_waits_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       power_up;
    logic [2:0] after_sel;
  } clns_init_strobe_t;

  function automatic logic [7:0] line_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

  // Init script, one entry per strobe
  function automatic clns_init_strobe_t init_strobe(input logic [3:0] step);
    clns_init_strobe_t s;
    case (step)
      4'd0:    s = '{nibble: 4'h3, power_up: 1'b1, after_sel: AFT_5000};
      4'd1:    s = '{nibble: 4'h3, power_up: 1'b0, after_sel: AFT_150};
      4'd2:    s = '{nibble: 4'h3, power_up: 1'b0, after_sel: AFT_1000};
      4'd3:    s = '{nibble: 4'h2, power_up: 1'b0, after_sel: AFT_1000};
      4'd4:    s = '{nibble: 4'h2, power_up: 1'b0, after_sel: AFT_ZERO};
      4'd5:    s = '{nibble: 4'h8, power_up: 1'b0, after_sel: AFT_CMD};
      4'd6:    s = '{nibble: 4'h0, power_up: 1'b0, after_sel: AFT_ZERO};
      4'd7:    s = '{nibble: 4'h8, power_up: 1'b0, after_sel: AFT_CMD};
      4'd8:    s = '{nibble: 4'h0, power_up: 1'b0, after_sel: AFT_ZERO};
      4'd9:    s = '{nibble: 4'h1, power_up: 1'b0, after_sel: AFT_CLEAR};
      4'd10:   s = '{nibble: 4'h0, power_up: 1'b0, after_sel: AFT_ZERO};
      4'd11:   s = '{nibble: 4'h6, power_up: 1'b0, after_sel: AFT_CMD};
      4'd12:   s = '{nibble: 4'h0, power_up: 1'b0, after_sel: AFT_ZERO};
      default: s = '{nibble: 4'hC, power_up: 1'b0, after_sel: AFT_CMD};
    endcase
    return s;
  endfunction

endpackage

[src/clns_if.sv]
// Request and strobe channel interfaces for the LCD nibble sequencer.
interface clns_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] byte_value;
  logic [1:0] row;
  logic [5:0] column;
  logic [2:0] glyph_slot;

  modport source (output valid, func, byte_value, row, column, glyph_slot, input ready);
  modport sink   (input valid, func, byte_value, row, column, glyph_slot, output ready);
endinterface

interface clns_strobe_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_before_us;
  logic [15:0] wait_after_us;
  logic        last;

  modport source (output valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  input ready);
  modport sink   (input valid, reg_select, nibble, wait_before_us, wait_after_us, last,
                  output ready);
endinterface

[src/clns_front.sv]
// Front end: accepts requests and turns each known one into one queued job.
module clns_front (
  clns_req_if.sink           req,
  input  logic               q_full,
  output logic               push,
  output clns_pkg::clns_job_t push_job
);

  logic       known;
  logic [7:0] cursor_addr;

  assign cursor_addr = clns_pkg::line_base(req.row) + {2'b00, req.column};

  always_comb begin
    known    = 1'b1;
    push_job = '{is_init: 1'b0, rs: 1'b0, data: req.byte_value,
                 after_sel: clns_pkg::AFT_CMD};
    case (req.func)
      clns_pkg::FUNC_INIT: begin
        push_job.is_init = 1'b1;
      end
      clns_pkg::FUNC_CMD: begin
      end
      clns_pkg::FUNC_DATA: begin
        push_job.rs        = 1'b1;
        push_job.after_sel = clns_pkg::AFT_CHAR;
      end
      clns_pkg::FUNC_CLEAR: begin
        push_job.data      = clns_pkg::CMD_CLEAR;
        push_job.after_sel = clns_pkg::AFT_CLEAR;
      end
      clns_pkg::FUNC_CURSOR: begin
        push_job.data = clns_pkg::CMD_SET_DDRAM | cursor_addr;
      end
      clns_pkg::FUNC_GLYPH: begin
        push_job.data = {clns_pkg::CGRAM_PREFIX, req.glyph_slot, 3'b000};
      end
      default: begin
        known = 1'b0;  // unused codes are swallowed
      end
    endcase
  end

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full && known;

endmodule

[src/clns_queue.sv]
// Short job queue between the front end and the strobe sequencer.
module clns_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clns_pkg::clns_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output clns_pkg::clns_job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  clns_pkg::clns_job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/clns_back.sv]
// Back end: expands queued jobs into nibble strobes with their waits.
module clns_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  clns_pkg::clns_job_t  head_job,
  input  clns_pkg::clns_waits_t waits,
  output logic                 pop,
  clns_strobe_if.source        strobe
);

  logic [3:0]  step;
  logic [3:0]  step_next;
  logic        load;
  logic        cur_last;
  logic        cur_power_up;
  logic [3:0]  cur_nibble;
  logic [2:0]  cur_sel;
  logic [15:0] cur_after;
  logic [16:0] clear_sum;
  logic [15:0] clear_total;
  clns_pkg::clns_init_strobe_t init_s;

  assign init_s = clns_pkg::init_strobe(step);

  // command wait plus clear wait, saturating
  assign clear_sum   = {1'b0, waits.command_wait} + {1'b0, waits.clear_wait};
  assign clear_total = clear_sum[16] ? 16'hFFFF : clear_sum[15:0];

  always_comb begin
    if (head_job.is_init) begin
      cur_nibble   = init_s.nibble;
      cur_power_up = init_s.power_up;
      cur_sel      = init_s.after_sel;
      cur_last     = (step == clns_pkg::INIT_LAST_STEP);
    end else begin
      // high nibble first, only the low nibble carries the wait
      cur_nibble   = step[0] ? head_job.data[3:0] : head_job.data[7:4];
      cur_power_up = 1'b0;
      cur_sel      = step[0] ? head_job.after_sel : clns_pkg::AFT_ZERO;
      cur_last     = step[0];
    end
  end

  always_comb begin
    case (cur_sel)
      clns_pkg::AFT_CMD:   cur_after = waits.command_wait;
      clns_pkg::AFT_CHAR:  cur_after = waits.char_wait;
      clns_pkg::AFT_CLEAR: cur_after = clear_total;
      clns_pkg::AFT_5000:  cur_after = 16'd5000;
      clns_pkg::AFT_150:   cur_after = 16'd150;
      clns_pkg::AFT_1000:  cur_after = 16'd1000;
      default:             cur_after = 16'd0;
    endcase
  end

  assign load      = head_valid && (!strobe.valid || strobe.ready);
  assign pop       = load && cur_last;
  assign step_next = cur_last ? 4'd0 : step + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      strobe.valid <= 1'b0;
    end else begin
      if (load) begin
        step <= step_next;
      end
      if (load) begin
        strobe.valid <= 1'b1;
      end else if (strobe.ready) begin
        strobe.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      strobe.reg_select     <= head_job.rs;
      strobe.nibble         <= cur_nibble;
      strobe.wait_before_us <= cur_power_up ? clns_pkg::POWER_UP_WAIT_US : 16'd0;
      strobe.wait_after_us  <= cur_after;
      strobe.last           <= cur_last;
    end
  end

endmodule

[src/char_lcd_nibble_sequencer.sv]
// Character LCD 4-bit nibble sequencer: top level.
//
// req carries one request per item: init, command, data byte, clear,
// cursor move or glyph slot select; func codes 6 and 7 are dropped.
// strobe carries one item per E strobe: RS, nibble, waits in us and a
// last flag on the final strobe of the request. The downstream timing
// engine owns E pulse width and delay counting, so writes to clocks_per_us
// and strobe_width_us are ignored here and do not affect any strobe.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect next cycle
// and must only be made while the block is idle.
// The first strobe of a request passes through the job queue and then
// the strobe register. The sequencer issues one strobe per cycle while
// strobe is ready; a request yields 2 strobes (byte kinds) or 14 (init).
// A queue of QUEUE_DEPTH jobs lets requests be taken while strobes are
// still being issued; req.ready drops when it is full.
// If the receiver stalls, the strobe register holds and the sequencer
// waits. Reset empties the queue, drops strobe.valid and restores the
// wait registers; no clearing pass is needed.
module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  clns_req_if.sink     req,
  clns_strobe_if.source strobe,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  clns_pkg::clns_waits_t waits;
  clns_pkg::clns_job_t   push_job;
  clns_pkg::clns_job_t   head_job;
  logic push;
  logic pop;
  logic q_full;
  logic head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      waits.command_wait <= clns_pkg::COMMAND_WAIT_RESET;
      waits.char_wait    <= clns_pkg::CHAR_WAIT_RESET;
      waits.clear_wait   <= clns_pkg::CLEAR_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        clns_pkg::REG_COMMAND_WAIT: waits.command_wait <= cfg_wdata;
        clns_pkg::REG_CHAR_WAIT:    waits.char_wait    <= cfg_wdata;
        clns_pkg::REG_CLEAR_WAIT:   waits.clear_wait   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  clns_front u_front (
    .req      (req),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  clns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .waits      (waits),
    .pop        (pop),
    .strobe     (strobe)
  );

endmodule

[dv/tb_char_lcd_nibble_sequencer.sv]
// Self-checking testbench for the character LCD nibble sequencer top level.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_sequencer;

  // Spare request codes, dropped by the block
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  // Init script contents
  localparam logic [3:0]  WAKE_NIBBLE     = 4'h3;
  localparam logic [3:0]  FOUR_BIT_NIBBLE = 4'h2;
  localparam logic [15:0] WAKE_WAIT_FIRST = 16'd5000;
  localparam logic [15:0] WAKE_WAIT_SHORT = 16'd150;
  localparam logic [15:0] WAKE_WAIT_LONG  = 16'd1000;
  localparam logic [7:0]  LCD_FUNC_SET    = 8'h28;
  localparam logic [7:0]  LCD_DISP_OFF    = 8'h08;
  localparam logic [7:0]  LCD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0]  LCD_DISP_ON     = 8'h0C;
  localparam logic [7:0]  CGRAM_BASE      = 8'h40;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int TAIL_CYCLES    = 20;
  localparam int PRINT_CAP      = 40;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
    logic [2:0] glyph_slot;
  } lcd_request_t;

  typedef struct packed {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before_us;
    logic [15:0] wait_after_us;
    logic        last;
  } lcd_strobe_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  clns_req_if    req_ch ();
  clns_strobe_if strobe_ch ();

  char_lcd_nibble_sequencer u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch.sink),
    .strobe   (strobe_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Local copy of the register file
  logic [7:0]  clocks_per_us;
  logic [15:0] strobe_width_us;
  logic [15:0] command_wait_us;
  logic [15:0] char_wait_us;
  logic [15:0] clear_wait_us;

  lcd_request_t pending_reqs[$];
  lcd_strobe_t  exp_strobes[$];

  logic req_taken;
  logic calm;
  int   send_gap;
  int   stall_left;
  int   idle_cycles;
  int   mismatches;
  int   strobes_checked;
  int   cfg_writes;
  int   kind_count[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [15:0] clear_wait_total();
    logic [16:0] sum;
    sum = {1'b0, command_wait_us} + {1'b0, clear_wait_us};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  task automatic add_strobe(input logic rs, input logic [3:0] nib, input logic [15:0] pre_wait,
                            input logic [15:0] after, input logic fin);
    lcd_strobe_t s;
    s.reg_select     = rs;
    s.nibble         = nib;
    s.wait_before_us = pre_wait;
    s.wait_after_us  = after;
    s.last           = fin;
    exp_strobes.push_back(s);
  endtask

  // High nibble first; only the low nibble carries the wait
  task automatic add_byte(input logic rs, input logic [7:0] b, input logic [15:0] after,
                          input logic fin);
    add_strobe(rs, b[7:4], 16'd0, 16'd0, 1'b0);
    add_strobe(rs, b[3:0], 16'd0, after, fin);
  endtask

  task automatic predict_strobes(input lcd_request_t r);
    logic [7:0] addr;
    case (r.row)
      2'd0:    addr = 8'h00;
      2'd1:    addr = 8'h40;
      2'd2:    addr = 8'h14;
      default: addr = 8'h54;
    endcase
    addr = addr + {2'b00, r.column};
    case (r.func)
      clns_pkg::FUNC_INIT: begin
        add_strobe(1'b0, WAKE_NIBBLE, clns_pkg::POWER_UP_WAIT_US, WAKE_WAIT_FIRST, 1'b0);
        add_strobe(1'b0, WAKE_NIBBLE, 16'd0, WAKE_WAIT_SHORT, 1'b0);
        add_strobe(1'b0, WAKE_NIBBLE, 16'd0, WAKE_WAIT_LONG, 1'b0);
        add_strobe(1'b0, FOUR_BIT_NIBBLE, 16'd0, WAKE_WAIT_LONG, 1'b0);
        add_byte(1'b0, LCD_FUNC_SET, command_wait_us, 1'b0);
        add_byte(1'b0, LCD_DISP_OFF, command_wait_us, 1'b0);
        add_byte(1'b0, clns_pkg::CMD_CLEAR, clear_wait_total(), 1'b0);
        add_byte(1'b0, LCD_ENTRY_MODE, command_wait_us, 1'b0);
        add_byte(1'b0, LCD_DISP_ON, command_wait_us, 1'b1);
      end
      clns_pkg::FUNC_CMD:    add_byte(1'b0, r.byte_value, command_wait_us, 1'b1);
      clns_pkg::FUNC_DATA:   add_byte(1'b1, r.byte_value, char_wait_us, 1'b1);
      clns_pkg::FUNC_CLEAR:  add_byte(1'b0, clns_pkg::CMD_CLEAR, clear_wait_total(), 1'b1);
      clns_pkg::FUNC_CURSOR: add_byte(1'b0, clns_pkg::CMD_SET_DDRAM | addr, command_wait_us,
                                      1'b1);
      clns_pkg::FUNC_GLYPH:  add_byte(1'b0, CGRAM_BASE + {2'b00, r.glyph_slot, 3'b000},
                                      command_wait_us, 1'b1);
      default: ;
    endcase
  endtask

  function automatic lcd_request_t make_req(input logic [2:0] f, input logic [7:0] b,
                                            input logic [1:0] rw, input logic [5:0] col,
                                            input logic [2:0] slot);
    lcd_request_t r;
    r.func       = f;
    r.byte_value = b;
    r.row        = rw;
    r.column     = col;
    r.glyph_slot = slot;
    return r;
  endfunction

  // Mostly byte-sized requests; init is long, spare codes are rare noise
  function automatic lcd_request_t rand_request();
    lcd_request_t r;
    int pick;
    r = make_req(clns_pkg::FUNC_CMD, 8'($urandom), 2'($urandom), 6'($urandom),
                 3'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 6)       r.func = clns_pkg::FUNC_INIT;
    else if (pick < 24) r.func = clns_pkg::FUNC_CMD;
    else if (pick < 50) r.func = clns_pkg::FUNC_DATA;
    else if (pick < 62) r.func = clns_pkg::FUNC_CLEAR;
    else if (pick < 80) r.func = clns_pkg::FUNC_CURSOR;
    else if (pick < 95) r.func = clns_pkg::FUNC_GLYPH;
    else if (pick < 98) r.func = FUNC_SPARE_6;
    else                r.func = FUNC_SPARE_7;
    return r;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      clns_pkg::REG_CLOCKS_PER_US: clocks_per_us   = val[7:0];
      clns_pkg::REG_STROBE_WIDTH:  strobe_width_us = val;
      clns_pkg::REG_COMMAND_WAIT:  command_wait_us = val;
      clns_pkg::REG_CHAR_WAIT:     char_wait_us    = val;
      clns_pkg::REG_CLEAR_WAIT:    clear_wait_us   = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [15:0] clk_us, input logic [15:0] strobe,
                         input logic [15:0] cmd, input logic [15:0] chr,
                         input logic [15:0] clr);
    cfg_write(clns_pkg::REG_CLOCKS_PER_US, clk_us);
    cfg_write(clns_pkg::REG_STROBE_WIDTH, strobe);
    cfg_write(clns_pkg::REG_COMMAND_WAIT, cmd);
    cfg_write(clns_pkg::REG_CHAR_WAIT, chr);
    cfg_write(clns_pkg::REG_CLEAR_WAIT, clr);
  endtask

  // Wait for every request to go in and every strobe to come out
  task automatic drain();
    while (pending_reqs.size() != 0 || req_ch.valid || exp_strobes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_reqs.push_back(rand_request());
  endtask

  // Request driver
  always @(negedge clk) begin : req_driver
    lcd_request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (send_gap > 0) begin
        send_gap     <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 && !calm && $urandom_range(0, 4) == 0) begin
        send_gap     <= $urandom_range(0, 8);
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt               = pending_reqs.pop_front();
        req_ch.func       <= nxt.func;
        req_ch.byte_value <= nxt.byte_value;
        req_ch.row        <= nxt.row;
        req_ch.column     <= nxt.column;
        req_ch.glyph_slot <= nxt.glyph_slot;
        req_ch.valid      <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Strobe receiver back-pressure
  always @(negedge clk) begin : strobe_sink
    if (rst) begin
      strobe_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      strobe_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left      <= $urandom_range(0, 8);
      strobe_ch.ready <= 1'b0;
    end else begin
      strobe_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    lcd_strobe_t want;
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        kind_count[req_ch.func] += 1;
        predict_strobes(make_req(req_ch.func, req_ch.byte_value, req_ch.row,
                                 req_ch.column, req_ch.glyph_slot));
      end
      if (strobe_ch.valid && strobe_ch.ready) begin
        if (exp_strobes.size() == 0) begin
          report_mismatch("unexpected strobe, nibble", strobe_ch.nibble, 0);
        end else begin
          want = exp_strobes.pop_front();
          strobes_checked++;
          if (strobe_ch.reg_select !== want.reg_select)
            report_mismatch("reg_select", strobe_ch.reg_select, want.reg_select);
          if (strobe_ch.nibble !== want.nibble)
            report_mismatch("nibble", strobe_ch.nibble, want.nibble);
          if (strobe_ch.wait_before_us !== want.wait_before_us)
            report_mismatch("wait_before_us", strobe_ch.wait_before_us, want.wait_before_us);
          if (strobe_ch.wait_after_us !== want.wait_after_us)
            report_mismatch("wait_after_us", strobe_ch.wait_after_us, want.wait_after_us);
          if (strobe_ch.last !== want.last)
            report_mismatch("last", strobe_ch.last, want.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (strobe_ch.valid && strobe_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d strobes outstanding",
               idle_cycles, exp_strobes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int k;
    rst             = 1'b1;
    calm            = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = clns_pkg::REG_CLOCKS_PER_US;
    cfg_wdata       = 16'd0;
    req_ch.valid    = 1'b0;
    req_ch.func     = clns_pkg::FUNC_INIT;
    req_ch.byte_value = 8'd0;
    req_ch.row      = 2'd0;
    req_ch.column   = 6'd0;
    req_ch.glyph_slot = 3'd0;
    strobe_ch.ready = 1'b0;
    req_taken       = 1'b0;
    send_gap        = 0;
    stall_left      = 0;
    idle_cycles     = 0;
    mismatches      = 0;
    strobes_checked = 0;
    cfg_writes      = 0;
    for (k = 0; k < 8; k++) kind_count[k] = 0;
    clocks_per_us   = 8'd50;
    strobe_width_us = 16'd500;
    command_wait_us = clns_pkg::COMMAND_WAIT_RESET;
    char_wait_us    = clns_pkg::CHAR_WAIT_RESET;
    clear_wait_us   = clns_pkg::CLEAR_WAIT_RESET;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset register values, every request kind and field extreme
    pending_reqs.push_back(make_req(clns_pkg::FUNC_INIT, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CMD, 8'h00, 2'd3, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CMD, 8'hFF, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_DATA, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_DATA, 8'hFF, 2'd3, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_DATA, 8'hA5, 2'd1, 6'd21, 3'd2));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_DATA, 8'h5A, 2'd2, 6'd42, 3'd5));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CLEAR, 8'hFF, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CURSOR, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CURSOR, 8'h00, 2'd1, 6'd39, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CURSOR, 8'h00, 2'd2, 6'd39, 3'd0));
    // base + column past 0x7F wraps into bit 7
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CURSOR, 8'h00, 2'd3, 6'd63, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CURSOR, 8'hFF, 2'd1, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_GLYPH, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_GLYPH, 8'hFF, 2'd3, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(FUNC_SPARE_6, 8'hFF, 2'd3, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(FUNC_SPARE_7, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_DATA, 8'h3C, 2'd0, 6'd0, 3'd0));
    drain();

    // Long waits at the top of range; clear wait saturates
    cfg_all(16'hFF01, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF);
    pending_reqs.push_back(make_req(clns_pkg::FUNC_INIT, 8'hFF, 2'd3, 6'd63, 3'd7));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CLEAR, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_DATA, 8'h81, 2'd0, 6'd0, 3'd0));
    queue_random(22);
    drain();

    // Command and clear waits at the bottom, char wait and widths at the top
    cfg_all(16'h00FF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    pending_reqs.push_back(make_req(clns_pkg::FUNC_INIT, 8'h00, 2'd0, 6'd0, 3'd0));
    pending_reqs.push_back(make_req(clns_pkg::FUNC_CLEAR, 8'h00, 2'd0, 6'd0, 3'd0));
    queue_random(12);
    // hold off mid-phase until the strobe side is empty
    drain();
    queue_random(12);
    drain();

    // Random settings, sum near saturation; spare indexes must be ignored
    cfg_all(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom_range(30000, 65535)),
            16'($urandom), 16'($urandom_range(30000, 65535)));
    for (k = clns_pkg::REG_CLEAR_WAIT + 1; k < 8; k++) cfg_write(3'(k), 16'($urandom));
    queue_random(25);
    drain();

    // Last stretch without idling on either side
    calm = 1'b1;
    cfg_all(16'($urandom), 16'($urandom_range(1, 65535)), 16'($urandom),
            16'($urandom), 16'($urandom));
    queue_random(25);
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (exp_strobes.size() != 0)
      report_mismatch("strobes never seen, count", exp_strobes.size(), 0);
    $display("requests: init %0d, command %0d, data %0d, clear %0d, cursor %0d, glyph %0d",
             kind_count[clns_pkg::FUNC_INIT], kind_count[clns_pkg::FUNC_CMD],
             kind_count[clns_pkg::FUNC_DATA], kind_count[clns_pkg::FUNC_CLEAR],
             kind_count[clns_pkg::FUNC_CURSOR], kind_count[clns_pkg::FUNC_GLYPH]);
    $display("spare %0d; %0d strobes checked across %0d register writes, %0d mismatches",
             kind_count[FUNC_SPARE_6] + kind_count[FUNC_SPARE_7],
             strobes_checked, cfg_writes, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
